>>> rtl/core/tms_pkg.sv
package tms_pkg;

    // Display and message store geometry. TEXT_DEPTH is a power of two, so a
    // message position wraps into the store by keeping its low address bits.
    localparam int WIDTH      = 20;
    localparam int TEXT_DEPTH = 64;
    localparam int ADDR_W     = $clog2(TEXT_DEPTH);

    // Field widths fixed by the item formats.
    localparam int COL_W  = 6;
    localparam int CODE_W = 8;
    localparam int LEN_W  = 7;

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(WIDTH - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(TEXT_DEPTH);
    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(1);
    localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;

    // Command codes of an input item.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [COL_W-1:0]  char_index;
        logic [CODE_W-1:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [CODE_W-1:0] glyph;
        logic              frame_end;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_FRAME
    } t_seq_state;

    // One column read handed from the sequencer to the output stage.
    typedef struct packed {
        logic             vld;
        logic [COL_W-1:0] column;
        logic             in_win;
        logic             last;
    } t_col_meta;

endpackage

>>> rtl/core/tms_ram.sv
module tms_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // One write port and one registered read port; read data holds while
    // the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tms_seq.sv
module tms_seq
    import tms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    input  logic [LEN_W-1:0]  i_text_length,
    input  logic              i_adv,
    output t_col_meta         o_issue,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_waddr,
    output logic [CODE_W-1:0] o_ram_wdata,
    output logic              o_ram_re,
    output logic [ADDR_W-1:0] o_ram_raddr
);

    t_seq_state       r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic [COL_W-1:0] r_win_left, n_win_left;
    logic [COL_W-1:0] r_win_right, n_win_right;
    logic [COL_W-1:0] r_text_first, n_text_first;
    logic [COL_W-1:0] r_text_last, n_text_last;

    logic             in_acc;
    logic             col_last;
    logic [COL_W-1:0] text_pos;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] len_m1;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign col_last = (r_col == COL_LAST);

    // Message position of the current column, wrapped to the field width.
    assign text_pos    = r_text_first + r_col - r_win_left;
    assign o_ram_raddr = text_pos[ADDR_W-1:0];

    // Length as used by the scroll phases, clamped to the store.
    always_comb begin
        priority if (i_text_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (i_text_length > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = i_text_length;
        end
    end
    assign len_m1 = len_eff - LEN_W'(1);

    // Sequencer: loads write the store at once; a tick walks the column
    // counter over the display, one read per cycle while the output stage advances, then moves the window.
    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_win_left   = r_win_left;
        n_win_right  = r_win_right;
        n_text_first = r_text_first;
        n_text_last  = r_text_last;
        o_ram_we     = 1'b0;
        o_ram_waddr  = i_in_data.char_index[ADDR_W-1:0];
        o_ram_wdata  = i_in_data.char_code;
        o_ram_re     = 1'b0;

        o_issue.vld    = (r_state == S_FRAME);
        o_issue.column = r_col;
        o_issue.in_win = (r_col >= r_win_left) && (r_col <= r_win_right);
        o_issue.last   = col_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_TICK) begin
                        n_state = S_FRAME;
                        n_col   = '0;
                    end else if ({1'b0, i_in_data.char_index} < LEN_MAX) begin
                        o_ram_we = 1'b1;
                    end
                end
            end
            S_FRAME: begin
                if (i_adv) begin
                    o_ram_re = 1'b1;
                    if (col_last) begin
                        n_state = S_IDLE;
                        // Entry, slide, restart and exit phases of the scroll.
                        priority if ({1'b0, r_text_last} < len_m1) begin
                            n_text_last = r_text_last + COL_W'(1);
                            if (r_win_left != '0) begin
                                n_win_left = r_win_left - COL_W'(1);
                            end else begin
                                n_text_first = r_text_first + COL_W'(1);
                            end
                        end else if (r_win_left != '0) begin
                            n_win_left  = r_win_left - COL_W'(1);
                            n_win_right = r_win_right - COL_W'(1);
                        end else if (r_win_right == '0) begin
                            n_win_left   = COL_LAST;
                            n_win_right  = COL_LAST;
                            n_text_first = '0;
                            n_text_last  = '0;
                        end else begin
                            n_win_right  = r_win_right - COL_W'(1);
                            n_text_first = r_text_first + COL_W'(1);
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_win_left   <= COL_LAST;
            r_win_right  <= COL_LAST;
            r_text_first <= '0;
            r_text_last  <= '0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_win_left   <= n_win_left;
            r_win_right  <= n_win_right;
            r_text_first <= n_text_first;
            r_text_last  <= n_text_last;
        end
    end

    // The column counter stays on the display during a frame.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAME) |-> (r_col <= COL_LAST))
        else $error("column counter ran past the last display column");

    // The visible window never inverts.
    a_win_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win_left <= r_win_right)
        else $error("window left edge passed the right edge");

    // Issuing the last column ends the frame.
    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAME && i_adv && col_last) |=> (r_state == S_IDLE))
        else $error("frame did not end after its last column");

endmodule

>>> rtl/core/tms_out.sv
module tms_out
    import tms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_col_meta         i_issue,
    input  logic [CODE_W-1:0] i_rdata,
    output logic              o_adv,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    t_col_meta r_s1;
    logic      r_out_vld;
    t_out_item r_out;

    // The whole column pipe moves when the output register is free.
    assign o_adv = !r_out_vld || !i_out_stall;

    // Read stage holds the column details while the store data arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (o_adv) begin
            r_s1 <= i_issue;
        end
    end

    // Output register picks the stored character or a space.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld       <= r_s1.vld;
            r_out.column    <= r_s1.column;
            r_out.glyph     <= r_s1.in_win ? i_rdata : SPACE_CODE;
            r_out.frame_end <= r_s1.last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // The frame end flag marks exactly the last display column.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.frame_end == (r_out.column == COL_LAST)))
        else $error("frame end flag on the wrong column");

endmodule

>>> rtl/core/text_marquee_scroller.sv
// Scrolling text marquee for a character display WIDTH columns wide.
// Input channel (i_in_valid / o_in_stall / i_in_data): a load item writes one
// message character into the store; a tick item emits a whole frame, one
// output transfer per column from column 0 to WIDTH-1, and then moves the
// visible window one step along the scroll. A tick holds the input stalled
// while the column counter steps once per cycle unless the output stalls,
// issuing one store read each. The first column of a frame passes through
// the read stage and the output register, the following ones one per cycle
// while the receiver takes them.
// Output channel (o_out_valid / i_out_stall / o_out_data): when the receiver
// stalls, the column pipe and the column counter freeze, so a frame stretches
// by the stalled cycles and no column is lost or repeated.
// i_cfg_we / i_cfg_wdata write the message length; write it only while idle.
// Reset empties the pipe and returns the window to the right edge with the
// length at one. The character store is not cleared: load every message
// position before it scrolls into view.
module text_marquee_scroller
    import tms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    logic [LEN_W-1:0]  r_text_length;
    t_col_meta         issue;
    logic              adv;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CODE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CODE_W-1:0] ram_rdata;

    // Message length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_text_length <= i_cfg_wdata;
        end
    end

    tms_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_text_length (r_text_length),
        .i_adv         (adv),
        .o_issue       (issue),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr)
    );

    tms_ram #(
        .DATA_W (CODE_W),
        .DEPTH  (TEXT_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tms_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_rdata     (ram_rdata),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> bench/text_marquee_scroller_tb.sv
module text_marquee_scroller_tb;
    import tms_pkg::*;

    // Drain wait after the last expected column, sized from WIDTH and the column pipe.
    localparam int DRAIN_CYCLES = WIDTH + 4;
    localparam int STUCK_LIMIT  = 4000;
    localparam int DIR_ROWS     = 14;
    localparam int PHASES       = 10;

    // One row of the directed stimulus. Where want_on is set, the frame is
    // all spaces except want_glyph at want_col.
    typedef struct packed {
        logic              cmd;
        logic [COL_W-1:0]  idx;
        logic [CODE_W-1:0] code;
        logic              want_on;
        logic [COL_W-1:0]  want_col;
        logic [CODE_W-1:0] want_glyph;
    } t_dir_row;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_data;

    // Marquee state mirrored by the predictor.
    logic [CODE_W-1:0] mq_store [TEXT_DEPTH];
    logic [LEN_W-1:0]  len_reg;
    logic [COL_W-1:0]  win_left;
    logic [COL_W-1:0]  win_right;
    logic [ADDR_W-1:0] msg_first;
    logic [ADDR_W-1:0] msg_last;

    t_out_item frame_expect [$];
    t_out_item col_want;
    int        fail_count  = 0;
    int        stuck_cycles = 0;
    int        send_pct = 0;
    int        recv_pct = 0;

    // Reset length, the upper extreme, a shrink mid-scroll, and out-of-range
    // lengths; a negative entry asks for a random length.
    int phase_len  [PHASES] = '{64, 5, 0, 127, 20, 21, 65, 1, -1, 2};
    int phase_items[PHASES] = '{40, 30, 40, 60, 50, 40, 40, 30, 30, 30};
    int phase_tick [PHASES] = '{90, 80, 85, 90, 85, 85, 80, 85, 70, 85};

    t_dir_row dir_table [DIR_ROWS] = '{
        '{CMD_LOAD, 6'd0,  8'h00,      1'b0, 6'd0,     8'h00},
        '{CMD_TICK, 6'd0,  8'h00,      1'b1, COL_LAST, 8'h00},
        '{CMD_LOAD, 6'd0,  8'hFF,      1'b0, 6'd0,     8'h00},
        '{CMD_TICK, 6'd63, 8'hFF,      1'b1, 6'd18,    8'hFF},
        '{CMD_LOAD, 6'd63, 8'hFF,      1'b0, 6'd0,     8'h00},
        '{CMD_LOAD, 6'd63, 8'h00,      1'b0, 6'd0,     8'h00},
        '{CMD_LOAD, 6'd0,  SPACE_CODE, 1'b0, 6'd0,     8'h00},
        '{CMD_TICK, 6'd0,  8'hFF,      1'b1, 6'd17,    SPACE_CODE},
        '{CMD_LOAD, 6'd0,  8'h5A,      1'b0, 6'd0,     8'h00},
        '{CMD_TICK, 6'd42, 8'hA5,      1'b0, 6'd0,     8'h00},
        '{CMD_LOAD, 6'd42, 8'hA5,      1'b0, 6'd0,     8'h00},
        '{CMD_LOAD, 6'd21, 8'h80,      1'b0, 6'd0,     8'h00},
        '{CMD_TICK, 6'd21, 8'h01,      1'b0, 6'd0,     8'h00},
        '{CMD_TICK, 6'd63, 8'h7F,      1'b0, 6'd0,     8'h00}
    };

    text_marquee_scroller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one input item to the mirrored state; a tick queues its frame
    // when record is set, then steps the window along the scroll.
    task automatic advance_marquee(input t_in_item it, input bit record);
        int        eff_len;
        int        pos;
        t_out_item res;
        if (it.cmd == CMD_LOAD) begin
            if (int'(it.char_index) < TEXT_DEPTH) begin
                mq_store[it.char_index] = it.char_code;
            end
            return;
        end
        for (int col = 0; col < WIDTH; col++) begin
            res.column    = COL_W'(col);
            res.glyph     = SPACE_CODE;
            res.frame_end = (col == WIDTH - 1);
            if (col >= int'(win_left) && col <= int'(win_right)) begin
                pos       = (int'(msg_first) + col - int'(win_left)) % TEXT_DEPTH;
                res.glyph = mq_store[pos];
            end
            if (record) begin
                frame_expect.push_back(res);
            end
        end

        // Out-of-range lengths are clamped into 1..TEXT_DEPTH.
        eff_len = (len_reg == 0) ? 1 :
                  (int'(len_reg) > TEXT_DEPTH) ? TEXT_DEPTH : int'(len_reg);
        if (int'(msg_last) < eff_len - 1) begin
            // Entry: text grows in from the right edge.
            msg_last++;
            if (win_left > 0) begin
                win_left--;
            end else begin
                msg_first++;
            end
        end else if (win_left != 0) begin
            // Slide: the whole message moves left.
            win_left--;
            win_right--;
        end else if (win_right == 0) begin
            // Restart from the right edge.
            win_left  = COL_LAST;
            win_right = COL_LAST;
            msg_first = '0;
            msg_last  = '0;
        end else begin
            // Exit: the text rotates off the left edge.
            win_right--;
            msg_first++;
        end
    endtask

    // Offer one item, with random sender gaps, and return at its transfer.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Write the length register once the block has gone idle.
    task automatic set_length(input logic [LEN_W-1:0] v);
        in_valid <= 1'b0;
        while (frame_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we  <= 1'b0;
        len_reg = v;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Output checker, progress watchdog and receiver stall generator.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (frame_expect.size() == 0) begin
                    $error("unexpected column transfer: column %0d glyph %0h",
                           out_data.column, out_data.glyph);
                    fail_count++;
                end else begin
                    col_want = frame_expect.pop_front();
                    check_field("column", col_want.column, out_data.column);
                    check_field("glyph", col_want.glyph, out_data.glyph);
                    check_field("frame_end", col_want.frame_end, out_data.frame_end);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        out_stall <= ($urandom_range(99) < recv_pct);
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_in_item  it;
        t_out_item frame_col;
        t_dir_row  row;
        len_reg   = LEN_RESET;
        win_left  = COL_LAST;
        win_right = COL_LAST;
        msg_first = '0;
        msg_last  = '0;
        send_pct  = 21;
        recv_pct  = 60;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole store so no read ever hits an unwritten entry.
        for (int k = 0; k < TEXT_DEPTH; k++) begin
            it.cmd        = CMD_LOAD;
            it.char_index = COL_W'(k);
            it.char_code  = CODE_W'($urandom);
            send_item(it);
            advance_marquee(it, 1'b1);
        end

        // Directed rows at the reset length.
        for (int k = 0; k < DIR_ROWS; k++) begin
            row           = dir_table[k];
            it.cmd        = row.cmd;
            it.char_index = row.idx;
            it.char_code  = row.code;
            send_item(it);
            advance_marquee(it, !row.want_on);
            if (row.want_on) begin
                for (int c = 0; c < WIDTH; c++) begin
                    frame_col.column    = COL_W'(c);
                    frame_col.glyph     = (c == int'(row.want_col)) ? row.want_glyph
                                                                    : SPACE_CODE;
                    frame_col.frame_end = (c == WIDTH - 1);
                    frame_expect.push_back(frame_col);
                end
            end
        end

        // Random phases, each under its own message length.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                send_pct = 60;
                recv_pct = 21;
            end else if (p == 7) begin
                send_pct = 0;
                recv_pct = 0;
            end
            if (phase_len[p] < 0) begin
                set_length(LEN_W'($urandom_range(127)));
            end else begin
                set_length(LEN_W'(phase_len[p]));
            end
            for (int n = 0; n < phase_items[p]; n++) begin
                it.cmd        = ($urandom_range(99) < phase_tick[p]) ? CMD_TICK : CMD_LOAD;
                it.char_index = COL_W'($urandom);
                it.char_code  = CODE_W'($urandom);
                send_item(it);
                advance_marquee(it, 1'b1);
            end
        end

        in_valid <= 1'b0;
        while (frame_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tms_pkg.sv
rtl/core/tms_ram.sv
rtl/core/tms_seq.sv
rtl/core/tms_out.sv
rtl/core/text_marquee_scroller.sv
bench/text_marquee_scroller_tb.sv
